FILE: hdl/rrts_pkg.sv
// Shared types and codes of the round-robin thread scheduler.
package rrts_pkg;

  // Operation codes of a request.
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_SPAWN  = 3'd1;
  localparam logic [2:0] OP_TERM   = 3'd2;
  localparam logic [2:0] OP_BLOCK  = 3'd3;
  localparam logic [2:0] OP_RESUME = 3'd4;
  localparam logic [2:0] OP_SLEEP  = 3'd5;
  localparam logic [2:0] OP_QUERY  = 3'd6;

  // Per-thread status codes.
  localparam logic [1:0] TS_FREE    = 2'd0;
  localparam logic [1:0] TS_READY   = 2'd1;
  localparam logic [1:0] TS_RUNNING = 2'd2;
  localparam logic [1:0] TS_BLOCKED = 2'd3;

  // Result status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_ERR   = 2'd1;
  localparam logic [1:0] STAT_RESET = 2'd2;

  localparam logic [31:0] QUANTA_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]  op;
    logic [6:0]  thread_id;
    logic        entry_valid;
    logic [15:0] sleep_quanta;
  } rrts_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] result_value;
    logic [6:0]  running_id;
    logic [31:0] total_quanta;
  } rrts_rsp_t;

endpackage

FILE: hdl/rrts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/round_robin_thread_scheduler_core.sv
// Top level of the round-robin thread scheduler: sequencer and thread tables.
//
// A request is taken when start is high and busy is low. It carries an op
// (tick, spawn, terminate, block, resume, sleep, query) and its operands.
// Exactly one result follows per request; it is shown on result for the
// single cycle in which done is high, and the receiver cannot hold it off.
// busy is high from acceptance through the cycle in which done is high.
// One sequencer walks the thread tables one RAM read at a time, so a new
// request waits until the last one is done: spawn scans slots from id 1,
// a removal from the ready queue or sleep list walks each entry, and a
// switch walks each sleeper.
// After reset, and after the main thread is terminated, a clearing pass
// writes every thread slot, one per cycle, while busy is high; a
// termination of the main thread then reports status 2.
module round_robin_thread_scheduler_core #(
  parameter int MAX_THREADS = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  rrts_pkg::rrts_req_t request,
  output logic               done,
  output rrts_pkg::rrts_rsp_t result
);
  import rrts_pkg::*;

  localparam int ID_W  = $clog2(MAX_THREADS);
  localparam int CNT_W = $clog2(MAX_THREADS + 1);
  localparam int SUM_W = CNT_W + 1;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_SPAWN_RD, S_SPAWN_CHK,
    S_RMF_RD, S_RMF_WR, S_RMS_RD, S_RMS_WR,
    S_SW_RD, S_SW_ID, S_SW_UPD, S_SW_OLD, S_SW_OLD2,
    S_SW_POP, S_SW_POP2, S_SW_RUN, S_DONE
  } state_t;

  state_t          state;
  rrts_req_t       req_q;
  logic            in_range;
  logic [CNT_W-1:0] i, k;
  logic [ID_W-1:0]  cur, nxt, head, running, clr_idx;
  logic [CNT_W-1:0] count, scount;
  logic            old_gone, rm_sleep, clr_out;
  logic [31:0]     total;
  logic [1:0]      status_r;
  logic [31:0]     value_r;

  // RAM ports.
  logic            st_we, sl_we, rq_we, rf_we, so_we;
  logic [ID_W-1:0] st_wa, sl_wa, rq_wa, rf_wa, so_wa;
  logic [ID_W-1:0] st_ra, sl_ra, rq_ra, rf_ra, so_ra;
  logic [1:0]      st_wd, st_q;
  logic [15:0]     sl_wd, sl_q;
  logic [31:0]     rq_wd, rq_q;
  logic [ID_W-1:0] rf_wd, rf_q, so_wd, so_q;

  logic            push_en;
  logic [ID_W-1:0] push_id;
  logic [ID_W-1:0] req_tid;
  logic            tid_ok;
  logic [15:0]     sl_dec;

  // Ring index: base plus offset, wrapped once at the table depth.
  function automatic logic [ID_W-1:0] wrap_idx(input logic [ID_W-1:0] base,
                                               input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(off);
    if (s >= SUM_W'(MAX_THREADS)) begin
      s = s - SUM_W'(MAX_THREADS);
    end
    return s[ID_W-1:0];
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] x);
    return (x == QUANTA_MAX) ? x : x + 32'd1;
  endfunction

  assign req_tid = ID_W'(req_q.thread_id);
  assign tid_ok  = in_range && (st_q != TS_FREE);
  assign sl_dec  = (sl_q != 16'd0) ? sl_q - 16'd1 : 16'd0;

  // Thread tables and queues.
  rrts_ram #(.WIDTH(2), .DEPTH(MAX_THREADS)) u_status (
    .clk, .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(st_ra), .rdata(st_q));
  rrts_ram #(.WIDTH(16), .DEPTH(MAX_THREADS)) u_sleep_left (
    .clk, .we(sl_we), .waddr(sl_wa), .wdata(sl_wd), .raddr(sl_ra), .rdata(sl_q));
  rrts_ram #(.WIDTH(32), .DEPTH(MAX_THREADS)) u_run_quanta (
    .clk, .we(rq_we), .waddr(rq_wa), .wdata(rq_wd), .raddr(rq_ra), .rdata(rq_q));
  rrts_ram #(.WIDTH(ID_W), .DEPTH(MAX_THREADS)) u_ready_fifo (
    .clk, .we(rf_we), .waddr(rf_wa), .wdata(rf_wd), .raddr(rf_ra), .rdata(rf_q));
  rrts_ram #(.WIDTH(ID_W), .DEPTH(MAX_THREADS)) u_sleep_order (
    .clk, .we(so_we), .waddr(so_wa), .wdata(so_wd), .raddr(so_ra), .rdata(so_q));

  // RAM addressing and writes for each sequencer step.
  always_comb begin
    st_we = 1'b0; st_wa = req_tid; st_wd = TS_FREE;
    sl_we = 1'b0; sl_wa = req_tid; sl_wd = 16'd0;
    rq_we = 1'b0; rq_wa = req_tid; rq_wd = 32'd0;
    so_we = 1'b0; so_wa = k[ID_W-1:0]; so_wd = cur;
    st_ra = req_tid; sl_ra = req_tid; rq_ra = req_tid;
    rf_ra = wrap_idx(head, i);
    so_ra = i[ID_W-1:0];
    push_en = 1'b0;
    push_id = cur;
    unique case (state)
      S_CLEAR: begin
        st_we = 1'b1; sl_we = 1'b1; rq_we = 1'b1;
        st_wa = clr_idx; sl_wa = clr_idx; rq_wa = clr_idx;
        st_wd = (clr_idx == '0) ? TS_RUNNING : TS_FREE;
        rq_wd = (clr_idx == '0) ? 32'd1 : 32'd0;
      end
      S_IDLE: begin
        st_ra = ID_W'(request.thread_id);
        sl_ra = ID_W'(request.thread_id);
        rq_ra = ID_W'(request.thread_id);
      end
      S_DECODE: begin
        unique case (req_q.op)
          OP_TERM: begin
            if (tid_ok && req_q.thread_id != 7'd0) begin
              st_we = 1'b1; sl_we = 1'b1; rq_we = 1'b1;
            end
          end
          OP_BLOCK: begin
            if (tid_ok && req_q.thread_id != 7'd0 && st_q != TS_BLOCKED) begin
              st_we = 1'b1; st_wd = TS_BLOCKED;
            end
          end
          OP_RESUME: begin
            if (tid_ok && st_q == TS_BLOCKED) begin
              st_we = 1'b1; st_wd = TS_READY;
              push_en = (sl_q == 16'd0);
              push_id = req_tid;
            end
          end
          OP_SLEEP: begin
            if (running != '0 && req_q.sleep_quanta != 16'd0) begin
              sl_we = 1'b1; sl_wa = running; sl_wd = req_q.sleep_quanta;
            end
          end
          default: begin
          end
        endcase
      end
      S_SPAWN_RD: begin
        st_ra = i[ID_W-1:0];
      end
      S_SPAWN_CHK: begin
        if (st_q == TS_FREE) begin
          st_we = 1'b1; sl_we = 1'b1; rq_we = 1'b1;
          st_wa = i[ID_W-1:0]; sl_wa = i[ID_W-1:0]; rq_wa = i[ID_W-1:0];
          st_wd = TS_READY;
          push_en = 1'b1;
          push_id = i[ID_W-1:0];
        end
      end
      // Sleep-list compaction keeps every entry but the removed thread.
      S_RMS_WR: begin
        if (so_q != req_tid) begin
          so_we = 1'b1;
          so_wd = so_q;
        end
      end
      S_SW_ID: begin
        st_ra = so_q; sl_ra = so_q;
      end
      S_SW_UPD: begin
        sl_we = 1'b1; sl_wa = cur; sl_wd = sl_dec;
        if (sl_dec == 16'd0) begin
          push_en = (st_q == TS_READY);
        end else begin
          so_we = 1'b1;
        end
      end
      S_SW_OLD: begin
        st_ra = running; sl_ra = running;
      end
      S_SW_OLD2: begin
        if (st_q != TS_BLOCKED) begin
          st_we = 1'b1; st_wa = running; st_wd = TS_READY;
          push_id = running;
          if (sl_q == 16'd0) begin
            push_en = 1'b1;
          end else if (scount != CNT_W'(MAX_THREADS)) begin
            so_we = 1'b1; so_wa = scount[ID_W-1:0]; so_wd = running;
          end
        end
      end
      S_SW_POP: begin
        rf_ra = head; rq_ra = '0;
      end
      S_SW_POP2: begin
        rq_ra = rf_q;
      end
      S_SW_RUN: begin
        rq_we = 1'b1; rq_wa = nxt; rq_wd = sat_inc(rq_q);
        st_we = 1'b1; st_wa = nxt; st_wd = TS_RUNNING;
      end
      default: begin
      end
    endcase
    if (count == CNT_W'(MAX_THREADS)) begin
      push_en = 1'b0;
    end
  end

  // Ready-queue writes: a push at the tail, or a compaction write.
  always_comb begin
    rf_we = 1'b0;
    rf_wa = wrap_idx(head, count);
    rf_wd = push_id;
    if (push_en) begin
      rf_we = 1'b1;
    end else if (state == S_RMF_WR && rf_q != req_tid) begin
      rf_we = 1'b1;
      rf_wa = wrap_idx(head, k);
      rf_wd = rf_q;
    end
  end

  // Sequencer state and registered results.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_idx  <= '0;
      clr_out  <= 1'b0;
      head     <= '0;
      count    <= '0;
      scount   <= '0;
      running  <= '0;
      total    <= 32'd1;
      status_r <= STAT_RESET;
      value_r  <= 32'd0;
    end else begin
      if (push_en) begin
        count <= count + CNT_W'(1);
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + ID_W'(1);
          if (clr_idx == ID_W'(MAX_THREADS - 1)) begin
            state <= clr_out ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            req_q    <= request;
            in_range <= 32'(request.thread_id) < 32'(MAX_THREADS);
            status_r <= STAT_ERR;
            value_r  <= 32'd0;
            state    <= S_DECODE;
          end
        end
        S_DECODE: begin
          i <= '0;
          k <= '0;
          state <= S_DONE;
          unique case (req_q.op)
            OP_TICK: begin
              old_gone <= 1'b0;
              state    <= S_SW_RD;
            end
            OP_SPAWN: begin
              if (req_q.entry_valid) begin
                i     <= CNT_W'(1);
                state <= S_SPAWN_RD;
              end
            end
            OP_TERM: begin
              if (tid_ok) begin
                if (req_q.thread_id == 7'd0) begin
                  clr_idx  <= '0;
                  clr_out  <= 1'b1;
                  head     <= '0;
                  count    <= '0;
                  scount   <= '0;
                  running  <= '0;
                  total    <= 32'd1;
                  status_r <= STAT_RESET;
                  state    <= S_CLEAR;
                end else if (req_tid == running) begin
                  old_gone <= 1'b1;
                  state    <= S_SW_RD;
                end else begin
                  status_r <= STAT_OK;
                  rm_sleep <= (sl_q != 16'd0);
                  if (st_q == TS_READY) begin
                    state <= S_RMF_RD;
                  end else if (sl_q != 16'd0) begin
                    state <= S_RMS_RD;
                  end
                end
              end
            end
            OP_BLOCK: begin
              if (tid_ok && req_q.thread_id != 7'd0) begin
                status_r <= STAT_OK;
                if (st_q != TS_BLOCKED) begin
                  if (req_tid == running) begin
                    old_gone <= 1'b0;
                    state    <= S_SW_RD;
                  end else if (sl_q == 16'd0) begin
                    rm_sleep <= 1'b0;
                    state    <= S_RMF_RD;
                  end
                end
              end
            end
            OP_RESUME: begin
              if (tid_ok) begin
                status_r <= STAT_OK;
              end
            end
            OP_SLEEP: begin
              if (running != '0 && req_q.sleep_quanta != 16'd0) begin
                old_gone <= 1'b0;
                state    <= S_SW_RD;
              end
            end
            OP_QUERY: begin
              if (tid_ok) begin
                status_r <= STAT_OK;
                value_r  <= rq_q;
              end
            end
            default: begin
            end
          endcase
        end
        S_SPAWN_RD: begin
          state <= (i < CNT_W'(MAX_THREADS)) ? S_SPAWN_CHK : S_DONE;
        end
        S_SPAWN_CHK: begin
          if (st_q == TS_FREE) begin
            status_r <= STAT_OK;
            value_r  <= 32'(i);
            state    <= S_DONE;
          end else begin
            i     <= i + CNT_W'(1);
            state <= S_SPAWN_RD;
          end
        end
        // Ready-queue removal keeps the order of the remaining entries.
        S_RMF_RD: begin
          if (i < count) begin
            state <= S_RMF_WR;
          end else begin
            count <= k;
            i     <= '0;
            k     <= '0;
            state <= rm_sleep ? S_RMS_RD : S_DONE;
          end
        end
        S_RMF_WR: begin
          if (rf_q != req_tid) begin
            k <= k + CNT_W'(1);
          end
          i     <= i + CNT_W'(1);
          state <= S_RMF_RD;
        end
        S_RMS_RD: begin
          if (i < scount) begin
            state <= S_RMS_WR;
          end else begin
            scount <= k;
            state  <= S_DONE;
          end
        end
        S_RMS_WR: begin
          if (so_q != req_tid) begin
            k <= k + CNT_W'(1);
          end
          i     <= i + CNT_W'(1);
          state <= S_RMS_RD;
        end
        // Switch: count down each sleeper once, in sleep order.
        S_SW_RD: begin
          if (i < scount) begin
            state <= S_SW_ID;
          end else begin
            scount <= k;
            state  <= S_SW_OLD;
          end
        end
        S_SW_ID: begin
          cur   <= so_q;
          state <= S_SW_UPD;
        end
        S_SW_UPD: begin
          if (sl_dec != 16'd0) begin
            k <= k + CNT_W'(1);
          end
          i     <= i + CNT_W'(1);
          state <= S_SW_RD;
        end
        S_SW_OLD: begin
          state <= old_gone ? S_SW_POP : S_SW_OLD2;
        end
        S_SW_OLD2: begin
          if (st_q != TS_BLOCKED && sl_q != 16'd0 && scount != CNT_W'(MAX_THREADS)) begin
            scount <= scount + CNT_W'(1);
          end
          state <= S_SW_POP;
        end
        S_SW_POP: begin
          if (count != '0) begin
            state <= S_SW_POP2;
          end else begin
            nxt   <= '0;
            state <= S_SW_RUN;
          end
        end
        S_SW_POP2: begin
          nxt   <= rf_q;
          head  <= wrap_idx(head, CNT_W'(1));
          count <= count - CNT_W'(1);
          state <= S_SW_RUN;
        end
        S_SW_RUN: begin
          running  <= nxt;
          total    <= sat_inc(total);
          status_r <= STAT_OK;
          state    <= S_DONE;
        end
        S_DONE: begin
          clr_out <= 1'b0;
          state   <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);
  assign result.status       = status_r;
  assign result.result_value = value_r;
  assign result.running_id   = 7'(running);
  assign result.total_quanta = total;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_THREADS))
    else $error("ready queue count beyond depth");
  a_lists_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> (SUM_W'(count) + SUM_W'(scount)) < SUM_W'(MAX_THREADS))
    else $error("thread found in ready queue and sleep list at once");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done)
    else $error("request accepted without entering work");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy)
    else $error("result strobe longer than one cycle");
`endif

endmodule

FILE: tb/tb.sv
// Self-checking testbench of the round-robin thread scheduler core.
`timescale 1ns / 100ps

module tb;
  import rrts_pkg::*;

  localparam int NT = 128;
  localparam int LIMIT = 10000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  rrts_req_t request = '0;
  rrts_rsp_t result;

  int errors = 0;
  int cycles = 0;

  round_robin_thread_scheduler_core #(.MAX_THREADS(NT)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .request(request), .done(done), .result(result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Prints one mismatch line and counts it.
  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Scheduler predictor and the queue of expected results.
  class sched_board;
    logic [1:0]  tstat [NT];
    logic [15:0] sleft [NT];
    logic [31:0] rq [NT];
    logic [6:0]  ready_q [$];
    logic [6:0]  sleepers [$];
    logic [6:0]  cur;
    logic [31:0] qtotal;
    rrts_rsp_t   pending [$];

    function void clear();
      for (int i = 0; i < NT; i++) begin
        tstat[i] = TS_FREE;
        sleft[i] = '0;
        rq[i] = '0;
      end
      ready_q.delete();
      sleepers.delete();
      cur = '0;
      qtotal = 32'd1;
      tstat[0] = TS_RUNNING;
      rq[0] = 32'd1;
    endfunction

    function void drop_ready(logic [6:0] id);
      for (int i = ready_q.size() - 1; i >= 0; i--)
        if (ready_q[i] == id) ready_q.delete(i);
    endfunction

    function void switch_thread(bit old_gone);
      logic [6:0] keep [$];
      logic [6:0] nxt;
      foreach (sleepers[i]) begin
        if (sleft[sleepers[i]] != 0) sleft[sleepers[i]]--;
        if (sleft[sleepers[i]] == 0) begin
          if (tstat[sleepers[i]] == TS_READY) ready_q = {ready_q, sleepers[i]};
        end else begin
          keep = {keep, sleepers[i]};
        end
      end
      sleepers = keep;
      if (!old_gone && tstat[cur] != TS_BLOCKED) begin
        tstat[cur] = TS_READY;
        if (sleft[cur] == 0) ready_q = {ready_q, cur};
        else sleepers = {sleepers, cur};
      end
      nxt = (ready_q.size() != 0) ? ready_q.pop_front() : 7'd0;
      cur = nxt;
      tstat[nxt] = TS_RUNNING;
      if (rq[nxt] != QUANTA_MAX) rq[nxt]++;
      if (qtotal != QUANTA_MAX) qtotal++;
    endfunction

    // Notes an accepted request and queues its expected result.
    function void note_request(rrts_req_t r);
      rrts_rsp_t e;
      int i;
      bit ok;
      logic [6:0] t;
      t = r.thread_id;
      ok = (tstat[t] != TS_FREE);
      e.status = STAT_ERR;
      e.result_value = '0;
      case (r.op)
        OP_TICK: begin
          switch_thread(1'b0);
          e.status = STAT_OK;
        end
        OP_SPAWN: begin
          for (i = 1; i < NT; i++) if (tstat[i] == TS_FREE) break;
          if (i < NT && r.entry_valid) begin
            tstat[i] = TS_READY;
            sleft[i] = '0;
            rq[i] = '0;
            ready_q = {ready_q, 7'(i)};
            e.result_value = i;
            e.status = STAT_OK;
          end
        end
        OP_TERM: if (ok) begin
          if (t == 0) begin
            clear();
            e.status = STAT_RESET;
          end else begin
            if (t == cur) begin
              tstat[t] = TS_FREE;
              sleft[t] = '0;
              rq[t] = '0;
              switch_thread(1'b1);
            end else begin
              if (tstat[t] == TS_READY) drop_ready(t);
              if (sleft[t] != 0)
                for (int j = sleepers.size() - 1; j >= 0; j--)
                  if (sleepers[j] == t) sleepers.delete(j);
              tstat[t] = TS_FREE;
              sleft[t] = '0;
              rq[t] = '0;
            end
            e.status = STAT_OK;
          end
        end
        OP_BLOCK: if (ok && t != 0) begin
          e.status = STAT_OK;
          if (tstat[t] != TS_BLOCKED) begin
            if (t == cur) begin
              tstat[t] = TS_BLOCKED;
              switch_thread(1'b0);
            end else begin
              if (sleft[t] == 0) drop_ready(t);
              tstat[t] = TS_BLOCKED;
            end
          end
        end
        OP_RESUME: if (ok) begin
          if (tstat[t] == TS_BLOCKED) begin
            tstat[t] = TS_READY;
            if (sleft[t] == 0) ready_q = {ready_q, t};
          end
          e.status = STAT_OK;
        end
        OP_SLEEP: if (cur != 0 && r.sleep_quanta != 0) begin
          sleft[cur] = r.sleep_quanta;
          switch_thread(1'b0);
          e.status = STAT_OK;
        end
        OP_QUERY: if (ok) begin
          e.result_value = rq[t];
          e.status = STAT_OK;
        end
        default: ;
      endcase
      e.running_id = cur;
      e.total_quanta = qtotal;
      pending = {pending, e};
    endfunction

    // Compares one result with the oldest expectation.
    task check_result(rrts_rsp_t g);
      rrts_rsp_t e;
      if (pending.size() == 0) begin
        report("unexpected result", g.status, 0);
        return;
      end
      e = pending.pop_front();
      if (g.status !== e.status) report("status", g.status, e.status);
      if (g.result_value !== e.result_value)
        report("result_value", g.result_value, e.result_value);
      if (g.running_id !== e.running_id) report("running_id", g.running_id, e.running_id);
      if (g.total_quanta !== e.total_quanta)
        report("total_quanta", g.total_quanta, e.total_quanta);
    endtask
  endclass

  sched_board board = new();

  // Result monitor and cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) board.check_result(result);
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Sends one request after a random gap and waits for its acceptance.
  // With no gap, start stays high straight into the next request.
  task automatic send(input logic [2:0] op, input logic [6:0] tid,
                      input logic ev, input logic [15:0] nq);
    rrts_req_t r;
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    r.op = op;
    r.thread_id = tid;
    r.entry_valid = ev;
    r.sleep_quanta = nq;
    request <= r;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    board.note_request(r);
  endtask

  // Picks a thread id that is mostly live.
  function automatic logic [6:0] pick_tid();
    int k;
    if ($urandom_range(0, 9) == 0) return 7'($urandom);
    for (k = 0; k < 20; k++) begin
      pick_tid = 7'($urandom_range(0, 15));
      if (board.tstat[pick_tid] != TS_FREE) return pick_tid;
    end
  endfunction

  task automatic drain();
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  initial begin
    int r;
    logic [2:0] op;
    board.clear();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: every op and each special case.
    send(OP_SPAWN, 0, 1'b1, 0);
    send(OP_SPAWN, 0, 1'b0, 0);
    send(OP_SPAWN, 0, 1'b1, 0);
    send(OP_SLEEP, 0, 1'b0, 16'd3);
    send(OP_TICK, 0, 0, 0);
    send(OP_SLEEP, 0, 1'b1, 16'd0);
    send(OP_SLEEP, 0, 1'b1, 16'd2);
    send(OP_BLOCK, 7'd2, 0, 0);
    send(OP_BLOCK, 7'd2, 0, 0);
    send(OP_BLOCK, 7'd0, 0, 0);
    send(OP_RESUME, 7'd1, 0, 0);
    send(OP_TICK, 0, 0, 0);
    send(OP_TICK, 0, 0, 0);
    send(OP_RESUME, 7'd2, 0, 0);
    send(OP_QUERY, 7'd0, 0, 0);
    send(OP_QUERY, 7'd127, 0, 0);
    send(OP_TERM, 7'd100, 0, 0);
    send(3'd7, 7'h7F, 1'b1, 16'hFFFF);
    send(OP_TERM, 7'd1, 0, 0);
    send(OP_SLEEP, 0, 1'b1, 16'hFFFF);
    send(OP_TERM, 7'd0, 0, 0);
    // Sender holds off until the block has drained.
    drain();
    for (int i = 0; i < 128; i++) send(OP_SPAWN, 0, 1'b1, 0);
    send(OP_QUERY, 7'd127, 0, 0);
    send(OP_TERM, 7'd0, 0, 0);

    // Random: mostly well-formed scheduling sequences.
    for (int n = 0; n < 1700; n++) begin
      r = $urandom_range(0, 99);
      if (r < 25) op = OP_TICK;
      else if (r < 40) op = OP_SPAWN;
      else if (r < 50) op = OP_TERM;
      else if (r < 62) op = OP_BLOCK;
      else if (r < 74) op = OP_RESUME;
      else if (r < 86) op = OP_SLEEP;
      else if (r < 97) op = OP_QUERY;
      else op = 3'($urandom);
      if (op == OP_TERM && pick_tid() == 0 && $urandom_range(0, 30) != 0) op = OP_QUERY;
      send(op, (op == OP_TERM && $urandom_range(0, 1)) ? board.cur : pick_tid(),
           $urandom_range(0, 9) != 0,
           $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 6)));
      if (n == 900) drain();
    end

    drain();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
